[rtl/sal_pkg.sv]
package sal_pkg;

    localparam int CAPACITY    = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [2:0] MODE_INSERT      = 3'd0;
    localparam logic [2:0] MODE_APPEND      = 3'd1;
    localparam logic [2:0] MODE_REMOVE      = 3'd2;
    localparam logic [2:0] MODE_REMOVE_LAST = 3'd3;
    localparam logic [2:0] MODE_READ        = 3'd4;
    localparam logic [2:0] MODE_CLEAR       = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAPACITY);

    typedef struct packed {
        logic [2:0]             mode;
        logic [IDX_W-1:0]       index;
        logic [ENTRY_WIDTH-1:0] entry_data;
    } request_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [ENTRY_WIDTH-1:0] read_data;
        logic [CNT_W-1:0]       size_now;
        logic                   is_full;
        logic                   is_empty;
    } result_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                   shift_up;
        logic                   shift_down;
        logic [IDX_W-1:0]       pos;
        logic [ENTRY_WIDTH-1:0] data;
    } cell_ctl_t;

endpackage

[rtl/shifting_array_list_unit.sv]
// The result is strobed on done in the cycle after start is taken.
// Throughput: one transaction per cycle; every cell of the row that shifts moves on the
// same edge, so the cost of insert and remove does not depend on the index.
// busy stays low; the receiver cannot stall and each result shows for one cycle.
// Reset (rst_n, async, active low): list empty, capacity limit 64;
// entry contents are not cleared.
module shifting_array_list_unit
    import sal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             done,
    output result_t          result
);

    cell_ctl_t              ctl;
    logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [ENTRY_WIDTH-1:0] row_rd;
    logic                   accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    sal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .row_rd   (row_rd),
        .ctl      (ctl),
        .done     (done),
        .result   (result)
    );

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [ENTRY_WIDTH-1:0] left_w;
            logic [ENTRY_WIDTH-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            sal_cell u_cell (
                .clk     (clk),
                .slot    (IDX_W'(g)),
                .ctl     (ctl),
                .left    (left_w),
                .right   (right_w),
                .data    (cell_data[g]),
                .rd_word (cell_rd[g])
            );
        end
    endgenerate

    // only the addressed cell drives a non-zero word
    always_comb
    begin
        row_rd = '0;
        for (int i = 0; i < CAPACITY; i++)
            row_rd = row_rd | cell_rd[i];
    end

endmodule

[rtl/sal_cell.sv]
module sal_cell
    import sal_pkg::*;
(
    input  logic                   clk,
    input  logic [IDX_W-1:0]       slot,
    input  cell_ctl_t              ctl,
    input  logic [ENTRY_WIDTH-1:0] left,
    input  logic [ENTRY_WIDTH-1:0] right,
    output logic [ENTRY_WIDTH-1:0] data,
    output logic [ENTRY_WIDTH-1:0] rd_word
);

    logic [ENTRY_WIDTH-1:0] data_reg;
    logic [ENTRY_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            if (slot == ctl.pos)
                data_next = ctl.data;
            else if (slot > ctl.pos)
                data_next = left;
        end
        else if (ctl.shift_down)
        begin
            if (slot >= ctl.pos)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // gated by the address match so the row can be OR-combined
    assign rd_word = (slot == ctl.pos) ? data_reg : '0;

endmodule

[rtl/sal_ctrl.sv]
module sal_ctrl
    import sal_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  request_t               request,
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_data,
    input  logic [ENTRY_WIDTH-1:0] row_rd,
    output cell_ctl_t              ctl,
    output logic                   done,
    output result_t                result
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic             done_reg;
    result_t          result_reg, result_next;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] pos_ext;
    logic [1:0]       status;
    logic [ENTRY_WIDTH-1:0] rd;

    always_comb
    begin
        if (cap_reg == '0)
            lim = CNT_W'(1);
        else if (cap_reg > CAP_RESET)
            lim = CAP_RESET;
        else
            lim = cap_reg;
    end

    assign pos_ext = {1'b0, request.index};

    always_comb
    begin
        ctl.shift_up   = 1'b0;
        ctl.shift_down = 1'b0;
        ctl.pos        = request.index;
        ctl.data       = request.entry_data;
        count_next     = count_reg;
        status         = ST_INVALID;
        rd             = '0;
        case (request.mode)
            MODE_INSERT:
            begin
                if (pos_ext > CNT_W'(lim - CNT_W'(1)) || pos_ext > count_reg)
                    status = ST_INVALID;
                else if (count_reg >= lim)
                    status = ST_FULL;
                else
                begin
                    status       = ST_OK;
                    ctl.shift_up = 1'b1;
                    count_next   = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            MODE_APPEND:
            begin
                ctl.pos = count_reg[IDX_W-1:0];
                if (count_reg >= lim)
                    status = ST_FULL;
                else
                begin
                    status       = ST_OK;
                    ctl.shift_up = 1'b1;
                    count_next   = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            MODE_REMOVE:
            begin
                if (pos_ext >= count_reg)
                    status = ST_INVALID;
                else
                begin
                    status         = ST_OK;
                    ctl.shift_down = 1'b1;
                    count_next     = CNT_W'(count_reg - CNT_W'(1));
                end
            end
            MODE_REMOVE_LAST:
            begin
                ctl.pos = IDX_W'(count_reg - CNT_W'(1));
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                begin
                    status         = ST_OK;
                    ctl.shift_down = 1'b1;
                    count_next     = CNT_W'(count_reg - CNT_W'(1));
                end
            end
            MODE_READ:
            begin
                if (pos_ext < count_reg)
                begin
                    status = ST_OK;
                    rd     = row_rd;
                end
            end
            MODE_CLEAR:
            begin
                status     = ST_OK;
                count_next = '0;
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
        if (!accept)
        begin
            ctl.shift_up   = 1'b0;
            ctl.shift_down = 1'b0;
            count_next     = count_reg;
        end
        result_next.status    = status;
        result_next.read_data = rd;
        result_next.size_now  = count_next;
        result_next.is_full   = (count_next >= lim);
        result_next.is_empty  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (cfg_we)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/sal_checker.sv]
module sal_checker
    import sal_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input result_t          result
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without transaction");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.size_now == '0)))
        else $error("empty flag disagrees with size");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.size_now <= CAP_RESET))
        else $error("size beyond built depth");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.read_data == '0))
        else $error("read data on failed transaction");

endmodule

bind shifting_array_list_unit sal_checker u_sal_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
